// ===== rtl/core/beam_reordered_running_mean_top_assert.svh =====
// assertion macros for the beam reordered running mean core
`ifndef BEAM_REORDERED_RUNNING_MEAN_TOP_ASSERT_SVH
`define BEAM_REORDERED_RUNNING_MEAN_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BRRM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brrm assertion failed");

// next-cycle implication, checked outside reset
`define BRRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brrm assertion failed");

`endif

// ===== rtl/core/brrm_pkg.sv =====
// shared constants, codes and types of the beam reordered running mean core
package brrm_pkg;

	localparam int MAX_BEAMS_DEF    = 8;
	localparam int MAX_FEATURES_DEF = 256;

	localparam int SUM_W    = 48;
	localparam int DVD_W    = 49;
	localparam int DSR_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUANT_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BEAM_COUNT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IN_SCALE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IN_ZERO_POINT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_INV_SCALE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_ZERO_POINT = 3'd6;

	// error codes
	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_SRC  = 2'd1;
	localparam logic [1:0] ERR_STEP = 2'd2;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/core/brrm_ram.sv =====
// generic single-write, single-read ram with registered read
module brrm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/brrm_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module brrm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  brrm_pkg::div_req_t req,
	output brrm_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(brrm_pkg::DVD_W + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [brrm_pkg::DVD_W-1:0]  dvd_q;
	logic [brrm_pkg::DSR_W-1:0]  rem_q;
	logic [brrm_pkg::DSR_W-1:0]  dsr_q;
	logic [brrm_pkg::DSR_W:0]    shifted;
	logic                        qbit;

	// trial subtraction
	always_comb begin
		shifted = {rem_q, dvd_q[brrm_pkg::DVD_W-1]};
		qbit    = (shifted >= {1'b0, dsr_q});
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(brrm_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[brrm_pkg::DVD_W-2:0], qbit};
			rem_q <= qbit ? brrm_pkg::DSR_W'(shifted - {1'b0, dsr_q})
			              : shifted[brrm_pkg::DSR_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ===== rtl/core/beam_reordered_running_mean_top.sv =====
// top level of the beam reordered running mean core
//
// channel   direction  handshake                 payload
// command   in         start && !busy            step, beam_index, feature_index,
//                                                source_beam, update_value
// result    out        done, one cycle           result_value, error_code
// config    in         cfg_we                    cfg_index, cfg_data
//
// an error item answers in the cycle after it is taken and busy stays low.
// a good item runs through the read, sum and magnitude states, in quantized mode also
// the two multiply halves and the accumulate state, then the 49-step bit-serial divider.
// busy is high while a good item is in work; one item is in work at a time.
// reset clears control state and sets the config registers to their defaults; the sum banks hold nothing
// defined until written, so no clearing pass runs.
// the receiver cannot stall: each result is shown for exactly one cycle.
`include "beam_reordered_running_mean_top_assert.svh"

module beam_reordered_running_mean_top #(
	parameter int MAX_BEAMS    = brrm_pkg::MAX_BEAMS_DEF,
	parameter int MAX_FEATURES = brrm_pkg::MAX_FEATURES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [15:0]                       step,
	input  logic [2:0]                        beam_index,
	input  logic [7:0]                        feature_index,
	input  logic [2:0]                        source_beam,
	input  logic signed [31:0]                update_value,
	output logic                              done,
	output logic signed [31:0]                result_value,
	output logic [1:0]                        error_code,
	input  logic                              cfg_we,
	input  logic [brrm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [brrm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int DEPTH  = MAX_BEAMS * MAX_FEATURES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW     = brrm_pkg::SUM_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_SUM, ST_MAG, ST_MLO, ST_MHI, ST_ACC, ST_DIV
	} state_t;

	state_t state_q;

	// configuration registers
	logic        quant_q;
	logic [3:0]  beam_count_q;
	logic [8:0]  feature_count_q;
	logic [31:0] in_scale_q;
	logic [7:0]  in_zp_q;
	logic [31:0] out_inv_q;
	logic [7:0]  out_zp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_q         <= 1'b0;
			beam_count_q    <= 4'd1;
			feature_count_q <= 9'd1;
			in_scale_q      <= 32'd65536;
			in_zp_q         <= 8'd0;
			out_inv_q       <= 32'd65536;
			out_zp_q        <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				brrm_pkg::REG_QUANT_MODE:     quant_q         <= cfg_data[0];
				brrm_pkg::REG_BEAM_COUNT:     beam_count_q    <= cfg_data[3:0];
				brrm_pkg::REG_FEATURE_COUNT:  feature_count_q <= cfg_data[8:0];
				brrm_pkg::REG_IN_SCALE:       in_scale_q      <= cfg_data;
				brrm_pkg::REG_IN_ZERO_POINT:  in_zp_q         <= cfg_data[7:0];
				brrm_pkg::REG_OUT_INV_SCALE:  out_inv_q       <= cfg_data;
				brrm_pkg::REG_OUT_ZERO_POINT: out_zp_q        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// bank address tables, indices folded into the bank size
	logic [ADDR_W-1:0] beam_base_tab [8];
	logic [ADDR_W-1:0] feat_tab [256];

	for (genvar g = 0; g < 8; g++) begin : g_beam_tab
		assign beam_base_tab[g] = ADDR_W'((g % MAX_BEAMS) * MAX_FEATURES);
	end
	for (genvar g = 0; g < 256; g++) begin : g_feat_tab
		assign feat_tab[g] = ADDR_W'(g % MAX_FEATURES);
	end

	// command decode
	logic              accept;
	logic [1:0]        err;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;

	always_comb begin
		accept = start && !busy;
		if ({1'b0, source_beam} >= beam_count_q) begin
			err = brrm_pkg::ERR_SRC;
		end else if (step == 16'd0) begin
			err = brrm_pkg::ERR_STEP;
		end else begin
			err = brrm_pkg::ERR_OK;
		end
		rd_addr = beam_base_tab[source_beam] + feat_tab[feature_index];
		wr_addr = beam_base_tab[beam_index] + feat_tab[feature_index];
	end

	// sum banks
	logic              re_bank;
	logic              we_even;
	logic              we_odd;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic [15:0]       step_s1;
	logic [31:0]       upd_s1;
	logic signed [SW-1:0] add_q;
	logic signed [SW-1:0] sum_q;
	logic [SW-1:0]     rd_even;
	logic [SW-1:0]     rd_odd;

	// previous sum plus update, saturated to the sum range
	logic signed [SW-1:0] prev_sum;
	logic signed [SW:0]   sum_wide;
	logic [SW-1:0]        sum_next;

	always_comb begin
		if (step_s1 == 16'd1) begin
			prev_sum = '0;
		end else begin
			prev_sum = step_s1[0] ? rd_even : rd_odd;
		end
		sum_wide = {prev_sum[SW-1], prev_sum} + {add_q[SW-1], add_q};
		if (sum_wide[SW] != sum_wide[SW-1]) begin
			sum_next = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			sum_next = sum_wide[SW-1:0];
		end
	end

	assign re_bank = accept && (err == brrm_pkg::ERR_OK);
	assign we_even = (state_q == ST_SUM) && !step_s1[0];
	assign we_odd  = (state_q == ST_SUM) && step_s1[0];

	brrm_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_bank_even (
		.clk(clk), .we(we_even), .waddr(wr_addr_s1), .wdata(sum_next),
		.re(re_bank), .raddr(rd_addr), .rdata(rd_even)
	);

	brrm_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_bank_odd (
		.clk(clk), .we(we_odd), .waddr(wr_addr_s1), .wdata(sum_next),
		.re(re_bank), .raddr(rd_addr), .rdata(rd_odd)
	);

	// update term
	logic signed [8:0]  qdiff;
	logic signed [41:0] qprod;

	always_comb begin
		qdiff = $signed({1'b0, upd_s1[7:0]}) - $signed({1'b0, in_zp_q});
		qprod = qdiff * $signed({1'b0, in_scale_q});
	end

	// shared 24 by 32 multiplier for the output scaling
	logic          neg_q;
	logic [SW-1:0] mag_q;
	logic [23:0]   mul_a;
	logic [55:0]   mul_p;
	logic [55:0]   lo_q;
	logic [55:0]   hi_q;
	logic [80:0]   acc_sum;

	always_comb begin
		mul_a   = (state_q == ST_MLO) ? mag_q[23:0] : mag_q[47:24];
		mul_p   = mul_a * out_inv_q;
		acc_sum = {1'b0, hi_q, 24'd0} + 81'(lo_q) + 81'({step_s1, 31'd0});
	end

	// divider
	brrm_pkg::div_req_t div_req;
	brrm_pkg::div_rsp_t div_rsp;
	logic               div_start_q;
	logic [brrm_pkg::DVD_W-1:0] dvd_q;
	logic [brrm_pkg::DSR_W-1:0] dsr_q;

	assign div_req.start    = div_start_q;
	assign div_req.dividend = dvd_q;
	assign div_req.divisor  = dsr_q;

	brrm_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	// final rounding, saturation and requantization
	logic [brrm_pkg::DVD_W-1:0] quo;
	logic [32:0]        lim;
	logic [32:0]        fmag;
	logic [32:0]        fres;
	logic [10:0]        qm;
	logic signed [12:0] qs;
	logic [31:0]        final_val;

	always_comb begin
		quo  = div_rsp.quotient;
		lim  = neg_q ? 33'h080000000 : 33'h07FFFFFFF;
		fmag = (quo > brrm_pkg::DVD_W'(lim)) ? lim : quo[32:0];
		fres = neg_q ? (33'd0 - fmag) : fmag;
		qm   = (quo > brrm_pkg::DVD_W'(1024)) ? 11'd1024 : quo[10:0];
		qs   = (neg_q ? -$signed({2'b00, qm}) : $signed({2'b00, qm}))
		       + $signed({5'd0, out_zp_q});
		if (quant_q) begin
			if (qs < 0) begin
				final_val = 32'd0;
			end else if (qs > 13'sd255) begin
				final_val = 32'd255;
			end else begin
				final_val = {24'd0, qs[7:0]};
			end
		end else begin
			final_val = fres[31:0];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done         <= 1'b0;
			div_start_q  <= 1'b0;
			result_value <= '0;
			error_code   <= brrm_pkg::ERR_OK;
		end else begin
			done        <= 1'b0;
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (err != brrm_pkg::ERR_OK) begin
							done         <= 1'b1;
							result_value <= '0;
							error_code   <= err;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_MAG;
				ST_MAG: begin
					if (quant_q) begin
						state_q <= ST_MLO;
					end else begin
						state_q     <= ST_DIV;
						div_start_q <= 1'b1;
					end
				end
				ST_MLO: state_q <= ST_MHI;
				ST_MHI: state_q <= ST_ACC;
				ST_ACC: begin
					state_q     <= ST_DIV;
					div_start_q <= 1'b1;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q      <= ST_IDLE;
						done         <= 1'b1;
						result_value <= final_val;
						error_code   <= brrm_pkg::ERR_OK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sign extension of a fixed-point update
	function automatic logic signed [SW-1:0] update_value_ext(input logic [31:0] v);
		return {{(SW-32){v[31]}}, v};
	endfunction

	// magnitude of the stored sum
	function automatic logic [SW-1:0] mag_q_next();
		return sum_q[SW-1] ? (SW'(0) - sum_q) : sum_q;
	endfunction

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1    <= step;
			upd_s1     <= update_value;
			wr_addr_s1 <= wr_addr;
		end
		if (state_q == ST_READ) begin
			add_q <= quant_q ? SW'(qprod) : SW'(update_value_ext(upd_s1));
		end
		if (state_q == ST_SUM) begin
			sum_q <= sum_next;
		end
		if (state_q == ST_MAG) begin
			neg_q <= sum_q[SW-1];
			mag_q <= sum_q[SW-1] ? (SW'(0) - sum_q) : sum_q;
			dvd_q <= {mag_q_next(), 1'b0} + brrm_pkg::DVD_W'(step_s1);
			dsr_q <= {step_s1, 1'b0};
		end
		if (state_q == ST_MLO) begin
			lo_q <= mul_p;
		end
		if (state_q == ST_MHI) begin
			hi_q <= mul_p;
		end
		if (state_q == ST_ACC) begin
			dvd_q <= acc_sum[80:32];
			dsr_q <= {1'b0, step_s1};
		end
	end

	assign busy = (state_q != ST_IDLE);

	`BRRM_ASSERT_NOW(a_one_bank, we_even || we_odd, !(we_even && we_odd))
	`BRRM_ASSERT_NEXT(a_err_now, accept && (err != brrm_pkg::ERR_OK),
		done && (error_code != brrm_pkg::ERR_OK) && !busy)
	`BRRM_ASSERT_NEXT(a_good_busy, accept && (err == brrm_pkg::ERR_OK), busy && !done)
	`BRRM_ASSERT_NOW(a_div_state, div_rsp.done, state_q == ST_DIV)

endmodule

// ===== verif/brrm_mean_checker.sv =====
// checker for the beam reordered running mean core: predicts each mean and compares
`timescale 1ns / 1ps

module brrm_mean_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [15:0]                     step,
	input  logic [2:0]                      beam_index,
	input  logic [7:0]                      feature_index,
	input  logic [2:0]                      source_beam,
	input  logic signed [31:0]              update_value,
	input  logic                            done,
	input  logic signed [31:0]              result_value,
	input  logic [1:0]                      error_code,
	input  logic                            cfg_we,
	input  logic [brrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brrm_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending_means,
	output int                              means_seen,
	output int                              errors_seen
);

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         err;
	} mean_t;

	localparam logic signed [63:0] SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_LO = -SUM_HI - 64'sd1;

	logic signed [47:0] sums_even [0:2047];
	logic signed [47:0] sums_odd  [0:2047];
	mean_t              mean_q[$];

	logic        quant_q;
	logic [3:0]  beams_q;
	logic [8:0]  feats_q;
	logic [31:0] in_scale_q;
	logic [7:0]  in_zp_q;
	logic [31:0] inv_scale_q;
	logic [7:0]  out_zp_q;

	initial begin
		fail_count = 0;
		pending_means = 0;
		means_seen = 0;
		errors_seen = 0;
		for (int i = 0; i < 2048; i++) begin
			sums_even[i] = '0;
			sums_odd[i] = '0;
		end
	end

	task automatic report(input string what, input logic signed [31:0] got,
			input logic signed [31:0] want);
		fail_count++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// running sum update and mean for one accepted command word
	task automatic compute_mean(input logic [15:0] st, input logic [2:0] bm,
			input logic [7:0] ft, input logic [2:0] sb, input logic signed [31:0] up,
			output mean_t m);
		logic signed [63:0] prev;
		logic signed [63:0] addv;
		logic signed [63:0] total;
		logic signed [63:0] diff;
		logic signed [63:0] q;
		logic [63:0]        mag;
		logic [63:0]        rm;
		logic [95:0]        prod;
		logic [95:0]        qm;
		logic               neg;
		m.value = '0;
		m.err = brrm_pkg::ERR_OK;
		if ({1'b0, sb} >= beams_q) begin
			m.err = brrm_pkg::ERR_SRC;
		end else if (st == 16'd0) begin
			m.err = brrm_pkg::ERR_STEP;
		end else begin
			prev = '0;
			if (st != 16'd1)
				prev = 64'(st[0] ? sums_even[{sb, ft}] : sums_odd[{sb, ft}]);
			if (quant_q) begin
				diff = $signed({56'd0, up[7:0]}) - $signed({56'd0, in_zp_q});
				addv = diff * $signed({32'd0, in_scale_q});
			end else begin
				addv = 64'(up);
			end
			total = prev + addv;
			if (total > SUM_HI) total = SUM_HI;
			if (total < SUM_LO) total = SUM_LO;
			if (st[0]) sums_odd[{bm, ft}] = total[47:0];
			else sums_even[{bm, ft}] = total[47:0];
			neg = total < 0;
			mag = neg ? -total : total;
			if (quant_q) begin
				prod = {32'd0, mag} * {64'd0, inv_scale_q} + ({80'd0, st} << 31);
				qm = (prod >> 32) / {80'd0, st};
				if (qm > 96'd1024) qm = 96'd1024;
				q = neg ? -$signed(qm[63:0]) : $signed(qm[63:0]);
				q = q + $signed({56'd0, out_zp_q});
				if (q < 0) q = '0;
				if (q > 255) q = 64'sd255;
				m.value = q[31:0];
			end else begin
				rm = (mag * 2 + {48'd0, st}) / {47'd0, st, 1'b0};
				if (neg) begin
					if (rm > 64'h8000_0000) rm = 64'h8000_0000;
					m.value = 32'(-$signed(rm));
				end else begin
					if (rm > 64'h7FFF_FFFF) rm = 64'h7FFF_FFFF;
					m.value = rm[31:0];
				end
			end
		end
	endtask

	// compare results, predict accepted words, follow register writes
	always @(posedge clk or negedge arst_n) begin
		mean_t m;
		if (!arst_n) begin
			quant_q <= 1'b0;
			beams_q <= 4'd1;
			feats_q <= 9'd1;
			in_scale_q <= 32'd65536;
			in_zp_q <= 8'd0;
			inv_scale_q <= 32'd65536;
			out_zp_q <= 8'd0;
			mean_q.delete();
			pending_means = 0;
		end else begin
			if (done) begin
				means_seen++;
				if (error_code != brrm_pkg::ERR_OK) errors_seen++;
				if (mean_q.size() == 0) begin
					report("unexpected result", result_value, 0);
				end else begin
					m = mean_q.pop_front();
					if (error_code !== m.err) report("error_code", error_code, m.err);
					if (result_value !== m.value) report("result_value", result_value, m.value);
				end
			end
			if (start && !busy) begin
				compute_mean(step, beam_index, feature_index, source_beam, update_value, m);
				mean_q.push_back(m);
			end
			pending_means = mean_q.size();
			if (cfg_we) begin
				case (cfg_index)
					brrm_pkg::REG_QUANT_MODE: quant_q <= cfg_data[0];
					brrm_pkg::REG_BEAM_COUNT: beams_q <= cfg_data[3:0];
					brrm_pkg::REG_FEATURE_COUNT: feats_q <= cfg_data[8:0];
					brrm_pkg::REG_IN_SCALE: in_scale_q <= cfg_data;
					brrm_pkg::REG_IN_ZERO_POINT: in_zp_q <= cfg_data[7:0];
					brrm_pkg::REG_OUT_INV_SCALE: inv_scale_q <= cfg_data;
					brrm_pkg::REG_OUT_ZERO_POINT: out_zp_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== verif/tb_beam_reordered_running_mean_top.sv =====
// testbench top for the beam reordered running mean core: stimulus and verdict
`timescale 1ns / 1ps

module tb_beam_reordered_running_mean_top;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int WORD_TARGET    = 400;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [15:0]                     step;
	logic [2:0]                      beam_index;
	logic [7:0]                      feature_index;
	logic [2:0]                      source_beam;
	logic signed [31:0]              update_value;
	logic                            done;
	logic signed [31:0]              result_value;
	logic [1:0]                      error_code;
	logic                            cfg_we;
	logic [brrm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [brrm_pkg::CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending_means;
	int means_seen;
	int errors_seen;
	int words_sent;
	int settings_used;
	int idle_pct;
	int quiet_cycles;
	logic [3:0] beams_cur;
	logic       quant_cur;
	// which bank entries hold a defined sum, by step parity of the write
	bit written [0:1][0:2047];

	beam_reordered_running_mean_top dut (.*);

	brrm_mean_checker checker_i (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic cfg_write(input logic [brrm_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == brrm_pkg::REG_BEAM_COUNT) beams_cur = data[3:0];
		if (idx == brrm_pkg::REG_QUANT_MODE) quant_cur = data[0];
	endtask

	// let the core drain before touching registers
	task automatic wait_idle();
		while (pending_means != 0) @(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	task automatic send_word(input logic [15:0] st, input logic [2:0] bm, input logic [7:0] ft,
			input logic [2:0] sb, input logic [31:0] up);
		int gap;
		start = 1'b1;
		step = st;
		beam_index = bm;
		feature_index = ft;
		source_beam = sb;
		update_value = up;
		while (busy) @(negedge clk);
		@(negedge clk);
		words_sent++;
		if ({1'b0, sb} < beams_cur && st != 16'd0) written[st[0]][{bm, ft}] = 1'b1;
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] pick_update();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 255) | ($urandom() & 32'hFFFF_FF00);
			3: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom();
		endcase
	endfunction

	// error words and stray writes, kept clear of never-written reads
	task automatic send_noise();
		logic [15:0] st;
		logic [2:0]  sb;
		logic [2:0]  bm;
		logic [7:0]  ft;
		bm = 3'($urandom_range(0, 7));
		ft = 8'($urandom_range(0, 255));
		sb = 3'($urandom_range(0, 7));
		st = 16'($urandom_range(0, 65535));
		case ($urandom_range(3))
			0: st = 16'd0;
			1: st = 16'd1;
			default: ;
		endcase
		if ({1'b0, sb} < beams_cur && st > 16'd1 && !written[~st[0]][{sb, ft}]) st = 16'd1;
		send_word(st, bm, ft, sb, pick_update());
	endtask

	// one decode: step one then a few steps of alternating parity
	task automatic run_decode();
		logic [7:0]  feats [3];
		logic [15:0] st;
		int          nfeat;
		int          nsteps;
		nfeat = $urandom_range(1, 3);
		nsteps = $urandom_range(2, 5);
		for (int i = 0; i < 3; i++) feats[i] = 8'($urandom_range(0, 255));
		st = 16'd1;
		for (int s = 0; s < nsteps; s++) begin
			for (int b = 0; b < beams_cur; b++) begin
				for (int f = 0; f < nfeat; f++) begin
					send_word(st, b[2:0], feats[f], 3'($urandom_range(0, beams_cur - 1)),
						pick_update());
					if ($urandom_range(9) == 0) send_noise();
				end
			end
			if ($urandom_range(1)) begin
				st = (st == 16'hFFFF) ? 16'd2 : st + 16'd1;
			end else begin
				st = {15'($urandom_range(0, 32767)), 1'b0} | {15'd0, ~st[0]};
				if (st == 16'd0) st = 16'd2;
			end
		end
	endtask

	task automatic set_registers(input int ph);
		logic [31:0] scale_pick [4];
		scale_pick = '{32'd0, 32'hFFFF_FFFF, 32'd65536, 32'd0};
		scale_pick[3] = $urandom();
		wait_idle();
		cfg_write(brrm_pkg::REG_QUANT_MODE, ph % 2);
		cfg_write(brrm_pkg::REG_BEAM_COUNT,
			(ph == 0) ? 1 : (ph == 1) ? 8 : $urandom_range(1, 8));
		cfg_write(brrm_pkg::REG_FEATURE_COUNT, (ph == 2) ? 256 : $urandom_range(1, 256));
		cfg_write(brrm_pkg::REG_IN_SCALE,
			(ph < 2) ? 32'd65536 : scale_pick[$urandom_range(3)]);
		cfg_write(brrm_pkg::REG_IN_ZERO_POINT, (ph == 3) ? 255 : $urandom_range(0, 255));
		cfg_write(brrm_pkg::REG_OUT_INV_SCALE,
			(ph < 2) ? 32'd65536 : scale_pick[$urandom_range(3)]);
		cfg_write(brrm_pkg::REG_OUT_ZERO_POINT, (ph == 5) ? 255 : $urandom_range(0, 255));
		settings_used++;
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		start = 1'b0;
		step = '0;
		beam_index = '0;
		feature_index = '0;
		source_beam = '0;
		update_value = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		words_sent = 0;
		settings_used = 1;
		idle_pct = 0;
		quiet_cycles = 0;
		beams_cur = 4'd1;
		quant_cur = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, step parity, error words, both modes
		send_word(16'd1, 3'd0, 8'd0, 3'd0, 32'h7FFF_FFFF);
		send_word(16'd1, 3'd7, 8'd255, 3'd0, 32'h8000_0000);
		send_word(16'd0, 3'd0, 8'd0, 3'd0, 32'd5);
		send_word(16'd1, 3'd2, 8'd1, 3'd1, 32'd5);
		send_word(16'd2, 3'd0, 8'd0, 3'd0, 32'h7FFF_FFFF);
		send_word(16'd65535, 3'd1, 8'd0, 3'd0, 32'h7FFF_FFFF);
		send_word(16'd2, 3'd3, 8'd0, 3'd0, 32'hFFFF_FFFF);
		start = 1'b0;
		wait_idle();
		cfg_write(brrm_pkg::REG_BEAM_COUNT, 8);
		cfg_write(brrm_pkg::REG_QUANT_MODE, 1);
		cfg_write(brrm_pkg::REG_IN_ZERO_POINT, 128);
		cfg_write(brrm_pkg::REG_OUT_ZERO_POINT, 128);
		send_word(16'd1, 3'd7, 8'd9, 3'd7, 32'hFFFF_FF00);
		send_word(16'd1, 3'd5, 8'd9, 3'd0, 32'h0000_00FF);
		send_word(16'd2, 3'd0, 8'd9, 3'd7, 32'h0000_0080);
		send_word(16'd3, 3'd1, 8'd9, 3'd0, 32'h0000_00FF);
		send_word(16'd0, 3'd1, 8'd9, 3'd0, 32'h0000_00FF);
		start = 1'b0;

		// random phases over register settings and idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			set_registers(ph);
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 75;
				2: idle_pct = 0;
				default: idle_pct = 22;
			endcase
			target = words_sent + WORD_TARGET / 8;
			while (words_sent < target) begin
				if ($urandom_range(4) == 0) send_noise();
				else run_decode();
			end
			start = 1'b0;
		end

		while (pending_means != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		$display("sent %0d command words over %0d register settings", words_sent,
			settings_used);
		$display("checked %0d results, %0d of them error words", means_seen, errors_seen);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
